FILE: hdl/owtr_pkg.sv
// Package for the one-wire temperature reader: word types, register indices,
// bus phase encoding, command bytes and the raw-to-hundredths conversion.
// Used by every module in the hdl folder; depends on nothing else.
package owtr_pkg;

  // Request codes carried in the op field of an input word.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_CONVERT = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Configuration register indices.
  localparam logic [2:0] REG_CHANNEL        = 3'd0;
  localparam logic [2:0] REG_SENSOR_TYPE    = 3'd1;
  localparam logic [2:0] REG_RESET_LOW      = 3'd2;
  localparam logic [2:0] REG_PRESENCE       = 3'd3;
  localparam logic [2:0] REG_SHORT_LOW      = 3'd4;
  localparam logic [2:0] REG_WRITE0_LOW     = 3'd5;
  localparam logic [2:0] REG_WRITE1_WAIT    = 3'd6;
  localparam logic [2:0] REG_READ_RECOVERY  = 3'd7;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned CHANNELS    = 4;

  // Reset values of the duration registers.
  localparam logic [TICK_W-1:0] RESET_LOW_DEFAULT     = 16'd2500;
  localparam logic [TICK_W-1:0] PRESENCE_DEFAULT      = 16'd255;
  localparam logic [TICK_W-1:0] SHORT_LOW_DEFAULT     = 16'd2;
  localparam logic [TICK_W-1:0] WRITE0_LOW_DEFAULT    = 16'd275;
  localparam logic [TICK_W-1:0] WRITE1_WAIT_DEFAULT   = 16'd260;
  localparam logic [TICK_W-1:0] READ_RECOVERY_DEFAULT = 16'd140;

  // Bus command bytes.
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  // Byte counts of the scratchpad read for each sensor type, and of the command write.
  localparam logic [2:0] READ_BYTES_12BIT = 3'd2;
  localparam logic [2:0] READ_BYTES_9BIT  = 3'd7;
  localparam logic [2:0] WRITE_BYTES      = 3'd2;

  // Constants of the conversion.
  localparam logic [7:0]  MSB_WHOLE_MASK = 8'hF8;
  localparam logic [7:0]  LSB_WHOLE_MASK = 8'hF0;
  localparam logic [7:0]  COUNT_PER_C    = 8'd16;
  localparam logic [15:0] HALF_LSB_OFFSET = 16'd25;
  localparam logic [15:0] NO_DEVICE_TEMP  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_RST_LOW = 3'd1,
    PH_PRES    = 3'd2,
    PH_WLOW    = 3'd3,
    PH_WREL    = 3'd4,
    PH_RLOW    = 3'd5,
    PH_RSET    = 3'd6,
    PH_RREC    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic       line_in;
  } in_word_t;

  typedef struct packed {
    logic [CHANNELS-1:0] line_drive_low;
    logic                busy_res;
    logic                done_res;
    logic                present;
    logic signed [15:0]  temperature;
  } out_word_t;

  typedef struct packed {
    logic [1:0]        channel;
    logic              sensor_type;
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] presence_ticks;
    logic [TICK_W-1:0] short_low_ticks;
    logic [TICK_W-1:0] write0_low_ticks;
    logic [TICK_W-1:0] write1_wait_ticks;
    logic [TICK_W-1:0] read_recovery_ticks;
  } cfg_t;

  // A programmed duration of zero behaves as one tick.
  function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] d);
    at_least_one = (d == '0) ? TICK_W'(1) : d;
  endfunction

  // Bit of the command currently being written: skip-ROM first, then the
  // function command chosen by the request.
  function automatic logic cur_bit(input logic [2:0] byte_index,
                                   input logic [2:0] bit_index,
                                   input logic       reading);
    logic [7:0] cmd;
    cmd = (byte_index == 3'd0) ? CMD_SKIP_ROM : (reading ? CMD_READ_SCRATCH : CMD_CONVERT);
    cur_bit = cmd[bit_index];
  endfunction

  // Raw 1/16 degree reading to hundredths of a degree, with the count-remain
  // refinement for the nine-bit sensor. All sums wrap as 8 or 16 bit words.
  function automatic logic [15:0] convert(input logic [7:0] raw_low,
                                          input logic [7:0] raw_high,
                                          input logic [7:0] counts,
                                          input logic       sensor_type);
    logic [7:0]  lsb;
    logic [7:0]  msb;
    logic        sign;
    logic [15:0] t2;
    logic [15:0] t;
    lsb = raw_low;
    msb = raw_high;
    if (sensor_type) begin
      msb = (raw_high & MSB_WHOLE_MASK) + {5'd0, raw_low[7:5]};
      lsb = ({raw_low[4:0], 3'd0} & LSB_WHOLE_MASK) + (COUNT_PER_C - counts);
    end
    sign = msb[7];
    t2 = {msb, lsb};
    if (sign) begin
      t2 = 16'd0 - t2;
    end
    t = {t2[13:0], 2'd0} + {t2[14:0], 1'd0};
    t = t + {2'd0, t2[15:2]};
    if (sign) begin
      t = 16'd0 - t;
    end
    if (sensor_type) begin
      t = t - HALF_LSB_OFFSET;
    end
    convert = t;
  endfunction

endpackage

FILE: hdl/one_wire_temperature_reader.sv
// Top level of the one-wire temperature reader: input register, sequencer,
// configuration registers and result register.
// Depends on owtr_pkg, owtr_cfg and owtr_seq.
//
// Usage. Every input word is one bus tick: op asks for a temperature
// conversion or a scratchpad read (ignored while a sequence runs, a plain
// tick otherwise) and line_in carries the sampled level of the selected line.
// Every accepted word yields exactly one result word with the open-drain
// drive pattern for the four lines, busy and done flags, the presence flag of
// the last bus reset and the last temperature in hundredths of a degree
// (-1 when no device answered a read).
// A word is captured in the input register; the sequencer then steps once on
// it and loads the result register. Throughput is one word per clock cycle
// while the receiver does not stall; words overlap, so a new word is taken
// while the previous result waits in the output register. If the receiver
// stalls, the result register holds its word and the input register fills;
// in_stall rises only when both are occupied.
// The configuration channel is always ready; the user must write it only while
// the block is idle, which the block does not enforce. The synchronous reset
// empties both registers, idles the bus and restores the register defaults.
module one_wire_temperature_reader (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  owtr_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output owtr_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import owtr_pkg::*;

  cfg_t      cfg;
  in_word_t  item;
  logic      item_valid;
  out_word_t res;
  logic      out_free;
  logic      step;
  logic      in_take;

  // The result register can load when empty or when its word leaves now.
  assign out_free  = !out_valid || !out_stall;
  assign step      = item_valid && out_free;
  assign in_stall  = item_valid && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  owtr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owtr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

endmodule

FILE: hdl/owtr_cfg.sv
// Configuration register file of the one-wire temperature reader.
// Depends on owtr_pkg for the register indices, defaults and cfg_t.
module owtr_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [owtr_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  wr_data,
  output owtr_pkg::cfg_t                   cfg
);
  import owtr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel             <= 2'd0;
      cfg.sensor_type         <= 1'b0;
      cfg.reset_low_ticks     <= RESET_LOW_DEFAULT;
      cfg.presence_ticks      <= PRESENCE_DEFAULT;
      cfg.short_low_ticks     <= SHORT_LOW_DEFAULT;
      cfg.write0_low_ticks    <= WRITE0_LOW_DEFAULT;
      cfg.write1_wait_ticks   <= WRITE1_WAIT_DEFAULT;
      cfg.read_recovery_ticks <= READ_RECOVERY_DEFAULT;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANNEL:       cfg.channel             <= wr_data[1:0];
        REG_SENSOR_TYPE:   cfg.sensor_type         <= wr_data[0];
        REG_RESET_LOW:     cfg.reset_low_ticks     <= wr_data;
        REG_PRESENCE:      cfg.presence_ticks      <= wr_data;
        REG_SHORT_LOW:     cfg.short_low_ticks     <= wr_data;
        REG_WRITE0_LOW:    cfg.write0_low_ticks    <= wr_data;
        REG_WRITE1_WAIT:   cfg.write1_wait_ticks   <= wr_data;
        REG_READ_RECOVERY: cfg.read_recovery_ticks <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/owtr_seq.sv
// Bus sequencer of the one-wire temperature reader: phase, tick counter,
// bit and byte counters, received bytes and the result of one tick.
// Depends on owtr_pkg for phase_t, the word types and conversion function.
module owtr_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  owtr_pkg::in_word_t  item,
  input  owtr_pkg::cfg_t      cfg,
  output owtr_pkg::out_word_t res
);
  import owtr_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  raw_low, raw_low_next;
  logic [7:0]  raw_high, raw_high_next;
  logic        line_high_seen_all, line_high_seen_all_next;
  logic        reading_request, reading_request_next;
  logic        last_present, last_present_next;
  logic [15:0] last_temperature, last_temperature_next;
  logic        finished;
  phase_t      active_phase;

  // Next state for one tick item.
  always_comb begin
    phase_t ph;
    logic   bit_now;
    ph                      = phase;
    tick_count_next         = tick_count;
    bit_index_next          = bit_index;
    byte_index_next         = byte_index;
    shift_byte_next         = shift_byte;
    raw_low_next            = raw_low;
    raw_high_next           = raw_high;
    line_high_seen_all_next = line_high_seen_all;
    reading_request_next    = reading_request;
    last_present_next       = last_present;
    last_temperature_next   = last_temperature;
    finished                = 1'b0;
    bit_now                 = 1'b0;

    if (ph == PH_IDLE && (item.op == OP_CONVERT || item.op == OP_READ)) begin
      reading_request_next = (item.op == OP_READ);
      ph                   = PH_RST_LOW;
      tick_count_next      = at_least_one(cfg.reset_low_ticks);
    end
    active_phase = ph;

    if (ph != PH_IDLE) begin
      if (ph == PH_PRES) begin
        line_high_seen_all_next = line_high_seen_all & item.line_in;
      end
      if (ph == PH_RSET) begin
        shift_byte_next[bit_index] = item.line_in;
      end
      tick_count_next = tick_count_next - 16'd1;
      if (tick_count_next == 16'd0) begin
        case (ph)
          PH_RST_LOW: begin
            line_high_seen_all_next = 1'b1;
            ph                      = PH_PRES;
            tick_count_next         = at_least_one(cfg.presence_ticks);
          end
          PH_PRES: begin
            last_present_next = ~line_high_seen_all_next;
            if (line_high_seen_all_next) begin
              if (reading_request_next) begin
                last_temperature_next = NO_DEVICE_TEMP;
              end
              ph              = PH_IDLE;
              tick_count_next = 16'd0;
              finished        = 1'b1;
            end else begin
              bit_index_next  = 3'd0;
              byte_index_next = 3'd0;
              bit_now         = cur_bit(3'd0, 3'd0, reading_request_next);
              ph              = PH_WLOW;
              tick_count_next = at_least_one(bit_now ? cfg.short_low_ticks
                                                     : cfg.write0_low_ticks);
            end
          end
          PH_WLOW: begin
            bit_now         = cur_bit(byte_index, bit_index, reading_request_next);
            ph              = PH_WREL;
            tick_count_next = bit_now ? at_least_one(cfg.write1_wait_ticks) : 16'd1;
          end
          PH_WREL: begin
            bit_index_next = bit_index + 3'd1;
            if (bit_index_next == 3'd0) begin
              byte_index_next = byte_index + 3'd1;
            end
            if (byte_index_next >= WRITE_BYTES) begin
              if (reading_request_next) begin
                bit_index_next  = 3'd0;
                byte_index_next = 3'd0;
                shift_byte_next = 8'd0;
                ph              = PH_RLOW;
                tick_count_next = at_least_one(cfg.short_low_ticks);
              end else begin
                ph              = PH_IDLE;
                tick_count_next = 16'd0;
                finished        = 1'b1;
              end
            end else begin
              bit_now         = cur_bit(byte_index_next, bit_index_next,
                                        reading_request_next);
              ph              = PH_WLOW;
              tick_count_next = at_least_one(bit_now ? cfg.short_low_ticks
                                                     : cfg.write0_low_ticks);
            end
          end
          PH_RLOW: begin
            ph              = PH_RSET;
            tick_count_next = 16'd1;
          end
          PH_RSET: begin
            ph              = PH_RREC;
            tick_count_next = at_least_one(cfg.read_recovery_ticks);
          end
          PH_RREC: begin
            bit_index_next  = bit_index + 3'd1;
            ph              = PH_RLOW;
            tick_count_next = at_least_one(cfg.short_low_ticks);
            if (bit_index_next == 3'd0) begin
              if (byte_index == 3'd0) begin
                raw_low_next = shift_byte_next;
              end else if (byte_index == 3'd1) begin
                raw_high_next = shift_byte_next;
              end
              byte_index_next = byte_index + 3'd1;
              if (byte_index_next >= (cfg.sensor_type ? READ_BYTES_9BIT
                                                      : READ_BYTES_12BIT)) begin
                last_temperature_next = convert(raw_low_next, raw_high_next,
                                                shift_byte_next, cfg.sensor_type);
                ph              = PH_IDLE;
                tick_count_next = 16'd0;
                finished        = 1'b1;
              end
            end
          end
          default: begin
            ph              = PH_IDLE;
            tick_count_next = 16'd0;
            finished        = 1'b1;
          end
        endcase
      end
    end
    phase_next = ph;
  end

  // Result of this tick.
  always_comb begin
    res.line_drive_low = '0;
    if (active_phase inside {PH_RST_LOW, PH_WLOW, PH_RLOW}) begin
      res.line_drive_low = CHANNELS'(1) << cfg.channel;
    end
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = finished;
    res.present     = last_present_next;
    res.temperature = last_temperature_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      tick_count         <= 16'd0;
      bit_index          <= 3'd0;
      byte_index         <= 3'd0;
      shift_byte         <= 8'd0;
      raw_low            <= 8'd0;
      raw_high           <= 8'd0;
      line_high_seen_all <= 1'b1;
      reading_request    <= 1'b0;
      last_present       <= 1'b0;
      last_temperature   <= 16'd0;
    end else if (step) begin
      phase              <= phase_next;
      tick_count         <= tick_count_next;
      bit_index          <= bit_index_next;
      byte_index         <= byte_index_next;
      shift_byte         <= shift_byte_next;
      raw_low            <= raw_low_next;
      raw_high           <= raw_high_next;
      line_high_seen_all <= line_high_seen_all_next;
      reading_request    <= reading_request_next;
      last_present       <= last_present_next;
      last_temperature   <= last_temperature_next;
    end
  end

endmodule

FILE: test/owtr_result_checker.sv
// Result checker for the one-wire temperature reader: watches the input, result and
// register channels, predicts every result word and compares it field by field.
// Depends on owtr_pkg for the word types, phase codes, register indices and constants.
module owtr_result_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  owtr_pkg::in_word_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  owtr_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [owtr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               failures,
  output int                               outstanding,
  output logic                             bus_idle
);
  timeunit 1ns;
  timeprecision 1ps;
  import owtr_pkg::*;

  cfg_t        regs;
  phase_t      phase;
  logic [15:0] ticks_left;
  logic [2:0]  bit_pos;
  logic [2:0]  byte_pos;
  logic [7:0]  shift_reg;
  logic [7:0]  raw_lo;
  logic [7:0]  raw_hi;
  logic        no_low_seen;
  logic        read_req;
  logic        seen_device;
  logic        sequence_ended;
  logic [15:0] reading;
  out_word_t   predicted_words[$];
  out_word_t   want;
  int          fail_tally = 0;

  function void load_phase(input phase_t p, input logic [15:0] d);
    phase = p;
    ticks_left = (d == 16'd0) ? 16'd1 : d;
  endfunction

  function logic next_cmd_bit();
    logic [7:0] cmd;
    if (byte_pos == 3'd0) begin
      cmd = CMD_SKIP_ROM;
    end else begin
      cmd = read_req ? CMD_READ_SCRATCH : CMD_CONVERT;
    end
    return cmd[bit_pos];
  endfunction

  function void start_write_slot();
    load_phase(PH_WLOW, next_cmd_bit() ? regs.short_low_ticks : regs.write0_low_ticks);
  endfunction

  function void end_sequence();
    phase = PH_IDLE;
    ticks_left = 16'd0;
    sequence_ended = 1'b1;
  endfunction

  // Raw scratchpad bytes to hundredths of a degree; every sum wraps at 8 or 16 bits.
  function logic [15:0] hundredths(input logic [7:0] lo, input logic [7:0] hi,
                                   input logic [7:0] remain, input logic nine_bit);
    logic [7:0]  l;
    logic [7:0]  h;
    logic        neg;
    logic [15:0] mag;
    logic [15:0] t;
    l = lo;
    h = hi;
    if (nine_bit) begin
      h = (hi & MSB_WHOLE_MASK) + (lo >> 5);
      l = ((lo << 3) & LSB_WHOLE_MASK) + (COUNT_PER_C - remain);
    end
    neg = h[7];
    mag = {h, l};
    if (neg) begin
      mag = 16'd0 - mag;
    end
    t = mag * 16'd6 + (mag >> 2);
    if (neg) begin
      t = 16'd0 - t;
    end
    if (nine_bit) begin
      t = t - HALF_LSB_OFFSET;
    end
    return t;
  endfunction

  function void phase_expired();
    case (phase)
      PH_RST_LOW: begin
        no_low_seen = 1'b1;
        load_phase(PH_PRES, regs.presence_ticks);
      end
      PH_PRES: begin
        seen_device = !no_low_seen;
        if (!seen_device) begin
          if (read_req) begin
            reading = NO_DEVICE_TEMP;
          end
          end_sequence();
        end else begin
          bit_pos = 3'd0;
          byte_pos = 3'd0;
          start_write_slot();
        end
      end
      PH_WLOW: load_phase(PH_WREL, next_cmd_bit() ? regs.write1_wait_ticks : 16'd1);
      PH_WREL: begin
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          byte_pos = byte_pos + 3'd1;
        end
        if (byte_pos >= WRITE_BYTES) begin
          if (read_req) begin
            bit_pos = 3'd0;
            byte_pos = 3'd0;
            shift_reg = 8'd0;
            load_phase(PH_RLOW, regs.short_low_ticks);
          end else begin
            end_sequence();
          end
        end else begin
          start_write_slot();
        end
      end
      PH_RLOW: load_phase(PH_RSET, 16'd1);
      PH_RSET: load_phase(PH_RREC, regs.read_recovery_ticks);
      PH_RREC: begin
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0) begin
          if (byte_pos == 3'd0) begin
            raw_lo = shift_reg;
          end else if (byte_pos == 3'd1) begin
            raw_hi = shift_reg;
          end
          byte_pos = byte_pos + 3'd1;
        end
        // The last byte read stays in the shift register; on the nine-bit sensor it is
        // the count-remain value.
        if (bit_pos == 3'd0 &&
            byte_pos >= (regs.sensor_type ? READ_BYTES_9BIT : READ_BYTES_12BIT)) begin
          reading = hundredths(raw_lo, raw_hi, shift_reg, regs.sensor_type);
          end_sequence();
        end else begin
          load_phase(PH_RLOW, regs.short_low_ticks);
        end
      end
      default: end_sequence();
    endcase
  endfunction

  function out_word_t step_master(input in_word_t w);
    out_word_t r;
    logic      pull;
    pull = 1'b0;
    sequence_ended = 1'b0;
    if (phase == PH_IDLE && (w.op == OP_CONVERT || w.op == OP_READ)) begin
      read_req = (w.op == OP_READ);
      load_phase(PH_RST_LOW, regs.reset_low_ticks);
    end
    if (phase != PH_IDLE) begin
      pull = (phase == PH_RST_LOW || phase == PH_WLOW || phase == PH_RLOW);
      if (phase == PH_PRES) begin
        no_low_seen = no_low_seen & w.line_in;
      end
      if (phase == PH_RSET) begin
        shift_reg[bit_pos] = w.line_in;
      end
      ticks_left = ticks_left - 16'd1;
      if (ticks_left == 16'd0) begin
        phase_expired();
      end
    end
    r.line_drive_low = pull ? (4'b0001 << regs.channel) : 4'b0000;
    r.busy_res = (phase != PH_IDLE);
    r.done_res = sequence_ended;
    r.present = seen_device;
    r.temperature = reading;
    return r;
  endfunction

  function void check_field(input string name, input int expected_val, input int actual_val);
    if (expected_val != actual_val) begin
      $error("%s: expected %0d, actual %0d", name, expected_val, actual_val);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = '{2'd0, 1'b0, RESET_LOW_DEFAULT, PRESENCE_DEFAULT, SHORT_LOW_DEFAULT,
               WRITE0_LOW_DEFAULT, WRITE1_WAIT_DEFAULT, READ_RECOVERY_DEFAULT};
      phase = PH_IDLE;
      ticks_left = 16'd0;
      bit_pos = 3'd0;
      byte_pos = 3'd0;
      shift_reg = 8'd0;
      raw_lo = 8'd0;
      raw_hi = 8'd0;
      no_low_seen = 1'b1;
      read_req = 1'b0;
      seen_device = 1'b0;
      sequence_ended = 1'b0;
      reading = 16'd0;
      predicted_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_words.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          fail_tally++;
        end else begin
          want = predicted_words.pop_front();
          check_field("line_drive_low", want.line_drive_low, out_data.line_drive_low);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("present", want.present, out_data.present);
          check_field("temperature", want.temperature, out_data.temperature);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL:       regs.channel = cfg_data[1:0];
          REG_SENSOR_TYPE:   regs.sensor_type = cfg_data[0];
          REG_RESET_LOW:     regs.reset_low_ticks = cfg_data;
          REG_PRESENCE:      regs.presence_ticks = cfg_data;
          REG_SHORT_LOW:     regs.short_low_ticks = cfg_data;
          REG_WRITE0_LOW:    regs.write0_low_ticks = cfg_data;
          REG_WRITE1_WAIT:   regs.write1_wait_ticks = cfg_data;
          REG_READ_RECOVERY: regs.read_recovery_ticks = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predicted_words.push_back(step_master(in_data));
      end
    end
    failures <= fail_tally;
    outstanding <= predicted_words.size();
    bus_idle <= (phase == PH_IDLE);
  end

endmodule

FILE: test/one_wire_temperature_reader_test.sv
// Testbench top for the one-wire temperature reader: clock, reset, stimulus and verdict.
// Depends on owtr_pkg, the block itself and owtr_result_checker, which does the checking.
module one_wire_temperature_reader_test;
  timeunit 1ns;
  timeprecision 1ps;
  import owtr_pkg::*;

  // The fourth op code has no meaning of its own; the block must treat it as a tick.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [7:0] ALL_REGS = 8'hFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_word_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     failures;
  int                     outstanding;
  logic                   bus_idle;

  // Stimulus controls. The percentage sets how often the emulated device holds the
  // line low: 0 is an empty bus, 100 a line stuck low, and the values in between
  // give presence pulses and scratchpad bits with a chosen bias.
  bit   idling_on = 1'b0;
  bit   hold_off = 1'b0;
  bit   stray_ops = 1'b0;
  int   low_pct = 50;
  int   sequence_ticks = 0;
  cfg_t settings;

  one_wire_temperature_reader DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  owtr_result_checker results (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding), .bus_idle(bus_idle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // This guard ends a run that does not finish in time.
  initial begin
    #200_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side. The single long hold-off is counted here, in cycles, while the
  // stimulus keeps offering words, so the block fills both registers and must stall
  // its input. Otherwise, with idling on, the receiver stalls in short random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one word and returns at the clock edge that accepts it. A gap in front of
  // the word lowers valid at an earlier edge than the one that raises it again, and a
  // stalled word is held unchanged.
  task automatic offer(input logic [1:0] op);
    in_word_t w;
    w.op = op;
    w.line_in = ($urandom_range(0, 99) >= low_pct);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Starts a conversion or a read and ticks the bus until the sequence is over. The
  // idle flag from the checker lags one accepted word behind, so the loop only stops
  // once a word that cannot start a sequence has seen an idle bus. Stray requests are
  // mixed in to check that a start during a sequence is ignored.
  task automatic run_sequence(input logic [1:0] request, input int pct);
    int pick;
    bit last_was_request;
    low_pct = pct;
    offer(request);
    sequence_ticks++;
    do begin
      pick = $urandom_range(0, 99);
      last_was_request = stray_ops && pick < 6;
      if (last_was_request) begin
        offer(pick < 3 ? OP_CONVERT : OP_READ);
      end else if (stray_ops && pick < 14) begin
        offer(OP_SPARE);
      end else begin
        offer(OP_TICK);
      end
      sequence_ticks++;
    end while (!bus_idle || last_was_request);
  endtask

  // Waits until every predicted result word has come back, so the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes the chosen registers from the settings record, one per handshake.
  task automatic apply_settings(input logic [7:0] which);
    logic [CFG_INDEX_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      if (which[i]) begin
        r = CFG_INDEX_W'(i);
        case (r)
          REG_CHANNEL:       cfg_data <= CFG_DATA_W'(settings.channel);
          REG_SENSOR_TYPE:   cfg_data <= CFG_DATA_W'(settings.sensor_type);
          REG_RESET_LOW:     cfg_data <= settings.reset_low_ticks;
          REG_PRESENCE:      cfg_data <= settings.presence_ticks;
          REG_SHORT_LOW:     cfg_data <= settings.short_low_ticks;
          REG_WRITE0_LOW:    cfg_data <= settings.write0_low_ticks;
          REG_WRITE1_WAIT:   cfg_data <= settings.write1_wait_ticks;
          default:           cfg_data <= settings.read_recovery_ticks;
        endcase
        cfg_index <= r;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t uniform_settings(input logic [1:0] ch, input logic nine_bit,
                                            input logic [15:0] d);
    return '{ch, nine_bit, d, d, d, d, d, d};
  endfunction

  // Mostly the shortest durations, so that many sequences fit in the run; a zero
  // must behave as one tick.
  function automatic logic [15:0] random_ticks();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) begin
      return 16'd0;
    end else if (r < 17) begin
      return 16'($urandom_range(1, 3));
    end
    return 16'($urandom_range(4, 24));
  endfunction

  function automatic int random_low_pct();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 3;
      2: return 97;
      3: return 100;
      default: return 50;
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A conversion with every register but the reset pulse length at its reset
    // value. The bus is empty, so the default presence window is run in full.
    settings = uniform_settings(2'd0, 1'b0, 16'd3);
    apply_settings(8'h04);
    run_sequence(OP_CONVERT, 0);
    drain();

    // Every duration at zero on the last channel. A line held low reads all zero
    // bytes; an empty bus gives the no-device reading on a read and leaves it alone
    // on a conversion. Spare op codes while idle must not start anything.
    settings = uniform_settings(2'd3, 1'b0, 16'd0);
    apply_settings(ALL_REGS);
    run_sequence(OP_READ, 100);
    repeat (3) offer(OP_SPARE);
    run_sequence(OP_READ, 0);
    run_sequence(OP_CONVERT, 0);
    drain();

    // Nine-bit sensor with count-remain, one-tick durations, requests while busy.
    // The long hold-off of the receiver falls into this stretch.
    settings = uniform_settings(2'd1, 1'b1, 16'd1);
    apply_settings(ALL_REGS);
    stray_ops = 1'b1;
    hold_off = 1'b1;
    run_sequence(OP_READ, 50);
    run_sequence(OP_READ, 3);
    run_sequence(OP_READ, 97);
    run_sequence(OP_CONVERT, 50);
    stray_ops = 1'b0;
    drain();

    // Random part: short sequences with random settings, device behaviour and
    // requests, with idling on both sides, until about 1800 words have been sent
    // in all, then a final stretch without idling.
    settings = uniform_settings(2'd0, 1'b0, 16'd1);
    apply_settings(ALL_REGS);
    idling_on = 1'b1;
    stray_ops = 1'b1;
    while (sequence_ticks < 1800) begin
      if (sequence_ticks > 1500) begin
        idling_on = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        drain();
        settings.channel = 2'($urandom_range(0, 3));
        settings.sensor_type = 1'($urandom_range(0, 1));
        settings.reset_low_ticks = random_ticks();
        settings.presence_ticks = random_ticks();
        settings.short_low_ticks = random_ticks();
        settings.write0_low_ticks = random_ticks();
        settings.write1_wait_ticks = random_ticks();
        settings.read_recovery_ticks = random_ticks();
        apply_settings(8'($urandom_range(1, 255)));
      end
      run_sequence($urandom_range(0, 1) ? OP_READ : OP_CONVERT, random_low_pct());
    end

    // Let the last words come back.
    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 5000 && outstanding != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
